// ----- rtl/pawmd_pkg.sv -----
// Shared types and constants for the PIR adaptive-window motion detector.
package pawmd_pkg;

    // Field and register widths
    localparam int SAMPLE_W   = 17;
    localparam int BASELINE_W = 18;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    // Working width for threshold math: baseline +/- half never leaves 19 bits
    localparam int CALC_W     = BASELINE_W + 1;

    // Low-pass filter shift (divide by 32)
    localparam int LPF_SHIFT = 5;

    // Threshold saturation limits
    localparam logic signed [CALC_W-1:0] SIGNED_MAX   = CALC_W'(32767);
    localparam logic signed [CALC_W-1:0] SIGNED_MIN   = -CALC_W'(32768);
    localparam logic signed [CALC_W-1:0] UNSIGNED_MAX = CALC_W'(65535);
    localparam logic signed [CALC_W-1:0] UNSIGNED_MIN = '0;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_SIZE  = 2'd0,
        REG_HOLD_SAMPLES = 2'd1,
        REG_SINGLE_ENDED = 2'd2
    } cfg_index_t;

endpackage

// ----- rtl/pir_adaptive_window_motion_detector.sv -----
// A word accepted into the input register moves to the result register once the
// result slot is free or taken. One word per cycle unless the result stalls; the
// threshold compare, baseline update and lockout count all fit in the single
// stage between input and result registers.
// A stalled result holds in the output register while one more word waits
// in the input register.
// Reset (rst_n low, asynchronous): baseline, lockout count, config registers
// and both valid flags clear to zero.
module pir_adaptive_window_motion_detector (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write port
    input  logic                                  cfg_wr_en,
    input  logic [pawmd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pawmd_pkg::CFG_W-1:0]           cfg_data,
    // sample channel
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [pawmd_pkg::SAMPLE_W-1:0] sample,
    // result channel
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  motion_active,
    output logic                                  motion_started,
    output logic                                  motion_ended,
    output logic signed [pawmd_pkg::BASELINE_W-1:0] baseline_out
);

    localparam int CW = pawmd_pkg::CALC_W;

    // Configuration registers
    logic [pawmd_pkg::CFG_W-1:0] window_size_reg;
    logic [pawmd_pkg::CFG_W-1:0] hold_samples_reg;
    logic                        single_ended_reg;

    // Input stage
    logic                                  s1_valid_reg;
    logic signed [pawmd_pkg::SAMPLE_W-1:0] s1_sample_reg;

    // Detector state
    logic signed [pawmd_pkg::BASELINE_W-1:0] baseline_reg, baseline_next;
    logic [pawmd_pkg::CFG_W-1:0]             lockout_reg, lockout_next;

    // Result register
    logic                                    out_valid_reg;
    logic                                    active_reg, started_reg, ended_reg;
    logic signed [pawmd_pkg::BASELINE_W-1:0] baseline_out_reg;

    logic advance;
    logic signed [CW-1:0] half, samp_ext, base_ext;
    logic signed [CW-1:0] hi_lim, lo_lim, sum_hi, sum_lo, upper, lower;
    logic signed [CW-1:0] lpf, nb;
    logic above, below, motion, ended;
    logic [pawmd_pkg::CFG_W-1:0] lockout_dec;

    // Handshake: input stage moves forward when the result slot is free or taken
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    // Configuration writes; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg  <= '0;
            hold_samples_reg <= '0;
            single_ended_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                pawmd_pkg::REG_WINDOW_SIZE:  window_size_reg  <= cfg_data;
                pawmd_pkg::REG_HOLD_SAMPLES: hold_samples_reg <= cfg_data;
                pawmd_pkg::REG_SINGLE_ENDED: single_ended_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Window thresholds, clamped to the sample range of the current mode
    always_comb
    begin
        half     = CW'({1'b0, window_size_reg[pawmd_pkg::CFG_W-1:1]});
        samp_ext = CW'(s1_sample_reg);
        base_ext = CW'(baseline_reg);
        hi_lim   = single_ended_reg ? pawmd_pkg::UNSIGNED_MAX : pawmd_pkg::SIGNED_MAX;
        lo_lim   = single_ended_reg ? pawmd_pkg::UNSIGNED_MIN : pawmd_pkg::SIGNED_MIN;
        sum_hi   = base_ext + half;
        sum_lo   = base_ext - half;

        if (sum_hi < lo_lim)
            upper = lo_lim;
        else if (sum_hi > hi_lim)
            upper = hi_lim;
        else
            upper = sum_hi;

        if (sum_lo < lo_lim)
            lower = lo_lim;
        else if (sum_lo > hi_lim)
            lower = hi_lim;
        else
            lower = sum_lo;
    end

    // Baseline update: jump on a window break, low-pass otherwise
    always_comb
    begin
        above = samp_ext > upper;
        below = samp_ext < lower;
        motion = above || below;
        // floor(s/32) + baseline - floor(baseline/32)
        lpf = (samp_ext >>> pawmd_pkg::LPF_SHIFT)
            + (base_ext - (base_ext >>> pawmd_pkg::LPF_SHIFT));
        if (above)
            nb = samp_ext - half;
        else if (below)
            nb = samp_ext + half;
        else
            nb = lpf;
        baseline_next = nb[pawmd_pkg::BASELINE_W-1:0];
    end

    // Lockout counter: count down, reload on motion
    always_comb
    begin
        lockout_dec  = (lockout_reg != '0) ? lockout_reg - 1'b1 : '0;
        ended        = (lockout_reg == pawmd_pkg::CFG_W'(1));
        lockout_next = motion ? hold_samples_reg : lockout_dec;
    end

    // Input stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_sample_reg <= sample;
    end

    // Detector state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_reg  <= '0;
            lockout_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                baseline_reg <= baseline_next;
                lockout_reg  <= lockout_next;
            end
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            active_reg       <= (lockout_next != '0);
            started_reg      <= motion;
            ended_reg        <= ended;
            baseline_out_reg <= baseline_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign motion_active  = active_reg;
    assign motion_started = started_reg;
    assign motion_ended   = ended_reg;
    assign baseline_out   = baseline_out_reg;

endmodule

// ----- rtl/pawmd_checker.sv -----
// Port-level checker for the motion detector, bound to the top level.
module pawmd_checker (
    input logic                                    clk,
    input logic                                    rst_n,
    input logic                                    in_valid,
    input logic                                    in_ready,
    input logic                                    out_valid,
    input logic                                    out_ready,
    input logic                                    motion_active,
    input logic                                    motion_started,
    input logic                                    motion_ended,
    input logic signed [pawmd_pkg::BASELINE_W-1:0] baseline_out
);

    // A stalled result word holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable(baseline_out) && $stable(motion_active)
            && $stable(motion_started) && $stable(motion_ended))
        else $error("result word changed while stalled");

    // An end of motion without a new break leaves the lockout idle
    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && motion_ended && !motion_started |-> !motion_active)
        else $error("motion still active after its end");

    // Active without a break on this word means an earlier break was delivered
    a_active_src: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !motion_active |=>
            !(out_valid && motion_active && !motion_started && !motion_ended))
        else $error("motion became active without a window break");

    // A rising result valid goes back to a sample taken through the input and result registers
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result word without an accepted sample");

endmodule

bind pir_adaptive_window_motion_detector pawmd_checker u_pawmd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .motion_active  (motion_active),
    .motion_started (motion_started),
    .motion_ended   (motion_ended),
    .baseline_out   (baseline_out)
);

// ----- tb/motion_result_checker.sv -----
// Scoreboard for the PIR motion detector: mirrors the registers, predicts and checks each word.
`timescale 1ns / 100ps

module motion_result_checker (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_wr_en,
    input  logic [pawmd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [pawmd_pkg::CFG_W-1:0]             cfg_data,
    input  logic                                    in_valid,
    input  logic                                    in_ready,
    input  logic signed [pawmd_pkg::SAMPLE_W-1:0]   sample,
    input  logic                                    out_valid,
    input  logic                                    out_ready,
    input  logic                                    motion_active,
    input  logic                                    motion_started,
    input  logic                                    motion_ended,
    input  logic signed [pawmd_pkg::BASELINE_W-1:0] baseline_out,
    output int                                      errors,
    output int                                      pending,
    output int                                      results_seen,
    output int                                      starts_seen,
    output int                                      ends_seen,
    output int                                      overlaps_seen
);

    // One expected result word
    typedef struct packed {
        logic                             active;
        logic                             started;
        logic                             ended;
        logic [pawmd_pkg::BASELINE_W-1:0] baseline;
    } detection_t;

    detection_t expected_results[$];
    detection_t oldest;

    // Register mirror and detector state, all zero after reset
    logic [pawmd_pkg::CFG_W-1:0] win_size    = '0;
    logic [pawmd_pkg::CFG_W-1:0] hold_count  = '0;
    logic                        unsigned_in = 1'b0;
    int                          center      = 0;
    logic [pawmd_pkg::CFG_W-1:0] lockout     = '0;

    int err_count   = 0;
    int n_pending   = 0;
    int n_results   = 0;
    int n_starts    = 0;
    int n_ends      = 0;
    int n_overlaps  = 0;

    assign errors        = err_count;
    assign pending       = n_pending;
    assign results_seen  = n_results;
    assign starts_seen   = n_starts;
    assign ends_seen     = n_ends;
    assign overlaps_seen = n_overlaps;

    function automatic int saturate(input int x, input int lo, input int hi);
        if (x < lo)
            return lo;
        if (x > hi)
            return hi;
        return x;
    endfunction

    // Threshold test, baseline update and lockout countdown for one sample
    function automatic detection_t predict_detection(
        input logic signed [pawmd_pkg::SAMPLE_W-1:0] s_in);
        int                               s;
        int                               half;
        int                               lo_lim;
        int                               hi_lim;
        int                               upper;
        int                               lower;
        int                               nb;
        logic [pawmd_pkg::BASELINE_W-1:0] nb_bits;
        detection_t                       d;

        s    = int'(s_in);
        half = int'(win_size >> 1);
        if (unsigned_in)
        begin
            lo_lim = int'(pawmd_pkg::UNSIGNED_MIN);
            hi_lim = int'(pawmd_pkg::UNSIGNED_MAX);
        end
        else
        begin
            lo_lim = int'(pawmd_pkg::SIGNED_MIN);
            hi_lim = int'(pawmd_pkg::SIGNED_MAX);
        end
        upper = saturate(center + half, lo_lim, hi_lim);
        lower = saturate(center - half, lo_lim, hi_lim);

        d = '0;
        if (s > upper)
        begin
            nb        = s - half;
            d.started = 1'b1;
        end
        else if (s < lower)
        begin
            nb        = s + half;
            d.started = 1'b1;
        end
        else
        begin
            // low-pass: arithmetic shift on int is a floor divide
            nb = (s >>> pawmd_pkg::LPF_SHIFT) + center - (center >>> pawmd_pkg::LPF_SHIFT);
        end
        nb_bits = nb[pawmd_pkg::BASELINE_W-1:0];
        center  = int'($signed(nb_bits));

        if (lockout != '0)
        begin
            lockout = lockout - 1'b1;
            if (lockout == '0)
                d.ended = 1'b1;
        end
        if (d.started)
            lockout = hold_count;

        d.active   = (lockout != '0);
        d.baseline = nb_bits;
        return d;
    endfunction

    task automatic check_field(input string what, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
            err_count++;
        end
    endtask

    // Sample every channel at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    pawmd_pkg::REG_WINDOW_SIZE:  win_size    = cfg_data;
                    pawmd_pkg::REG_HOLD_SAMPLES: hold_count  = cfg_data;
                    pawmd_pkg::REG_SINGLE_ENDED: unsigned_in = cfg_data[0];
                    default: ;
                endcase
            end

            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result word with nothing expected (baseline %0d)",
                             $time, baseline_out);
                    err_count++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    check_field("motion_active", oldest.active, motion_active);
                    check_field("motion_started", oldest.started, motion_started);
                    check_field("motion_ended", oldest.ended, motion_ended);
                    check_field("baseline_out", int'($signed(oldest.baseline)),
                                int'(baseline_out));
                    n_results++;
                    if (oldest.started)
                        n_starts++;
                    if (oldest.ended)
                        n_ends++;
                    if (oldest.started && oldest.ended)
                        n_overlaps++;
                end
            end

            if (in_valid && in_ready)
                expected_results.push_back(predict_detection(sample));

            n_pending = expected_results.size();
        end
    end

endmodule

// ----- tb/tb_pir_adaptive_window_motion_detector.sv -----
// Top of the PIR motion detector testbench: clock, reset, stimulus, idling and verdict.
`timescale 1ns / 100ps

module tb_pir_adaptive_window_motion_detector;

    localparam int DUT_LATENCY     = 2;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_PHASES   = 10;
    localparam int WORDS_PER_PHASE = 200;
    localparam logic [pawmd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                                    clk        = 1'b0;
    logic                                    rst_n      = 1'b0;
    logic                                    cfg_wr_en  = 1'b0;
    logic [pawmd_pkg::CFG_IDX_W-1:0]         cfg_index  = '0;
    logic [pawmd_pkg::CFG_W-1:0]             cfg_data   = '0;
    logic                                    in_valid   = 1'b0;
    logic                                    in_ready;
    logic signed [pawmd_pkg::SAMPLE_W-1:0]   sample     = '0;
    logic                                    out_valid;
    logic                                    out_ready  = 1'b0;
    logic                                    motion_active;
    logic                                    motion_started;
    logic                                    motion_ended;
    logic signed [pawmd_pkg::BASELINE_W-1:0] baseline_out;

    int errors;
    int pending;
    int results_seen;
    int starts_seen;
    int ends_seen;
    int overlaps_seen;

    // Idling control for the sender and the receiver
    int tx_idle_pct = 20;
    int rx_idle_pct = 20;
    bit hold_req    = 1'b0;

    // Stimulus state
    int words_sent  = 0;
    int level       = 0;
    int phase_win   = 0;
    bit phase_uns   = 1'b0;

    pir_adaptive_window_motion_detector i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample         (sample),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .motion_active  (motion_active),
        .motion_started (motion_started),
        .motion_ended   (motion_ended),
        .baseline_out   (baseline_out)
    );

    motion_result_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample         (sample),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .motion_active  (motion_active),
        .motion_started (motion_started),
        .motion_ended   (motion_ended),
        .baseline_out   (baseline_out),
        .errors         (errors),
        .pending        (pending),
        .results_seen   (results_seen),
        .starts_seen    (starts_seen),
        .ends_seen      (ends_seen),
        .overlaps_seen  (overlaps_seen)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap(input int pct);
        if (int'($urandom_range(99)) >= pct)
            return 0;
        if ($urandom_range(9) == 0)
            return int'($urandom_range(40, 10));
        return int'($urandom_range(3, 1));
    endfunction

    // Offer one sample word and hold it until taken; returns at a falling edge
    task automatic send_word(input int v);
        int gap;
        gap = pick_gap(tx_idle_pct);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        sample   = v[pawmd_pkg::SAMPLE_W-1:0];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [pawmd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pawmd_pkg::CFG_W-1:0] data);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // Drain: stop offering, wait out every expected word plus the pipe
    task automatic wait_idle();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DUT_LATENCY + 1) @(negedge clk);
    endtask

    // Next random sample: a drifting level with noise, window-breaking spikes and wild values
    task automatic next_sample(output int x);
        int r;
        int lo;
        int hi;
        int noise;
        int half;

        lo    = phase_uns ? 0 : -32768;
        hi    = phase_uns ? 65535 : 32767;
        half  = phase_win / 2;
        noise = phase_win / 4 + 2;
        r     = int'($urandom_range(99));
        if (r < 8)
        begin
            x = int'($urandom_range(98303)) - 32768;
        end
        else if (r < 22)
        begin
            x = half + int'($urandom_range(2000, 1));
            x = ($urandom_range(1) == 0) ? level + x : level - x;
            if ($urandom_range(2) == 0)
                level = x;
        end
        else
        begin
            level = level + int'($urandom_range(20)) - 10;
            x     = level + int'($urandom_range(2 * noise)) - noise;
        end
        if (level < lo)
            level = lo;
        if (level > hi)
            level = hi;
        if (x < -32768)
            x = -32768;
        if (x > 65535)
            x = 65535;
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int stall_left;
        int g;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            if (stall_left > 0)
            begin
                out_ready = 1'b0;
                stall_left--;
            end
            else
            begin
                g = pick_gap(rx_idle_pct);
                if (g > 0)
                begin
                    out_ready  = 1'b0;
                    stall_left = g - 1;
                end
                else
                begin
                    out_ready = 1'b1;
                end
            end
        end
    end

    // Watchdog: too many cycles with no word moving on either channel
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("** pir_adaptive_window_motion_detector: FAILED **");
        $finish;
    end

    // Main stimulus
    initial
    begin
        int x;
        logic [pawmd_pkg::CFG_W-1:0] win;
        logic [pawmd_pkg::CFG_W-1:0] hold;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset settings: zero-width window, zero hold, signed samples
        send_word(0);
        send_word(1);
        send_word(-1);
        send_word(32767);
        send_word(-32768);
        send_word(65535);

        // Normal window, short hold; ignored write to the spare index
        wait_idle();
        write_reg(pawmd_pkg::REG_WINDOW_SIZE, 16'd100);
        write_reg(pawmd_pkg::REG_HOLD_SAMPLES, 16'd3);
        write_reg(pawmd_pkg::REG_SINGLE_ENDED, 16'h0000);
        write_reg(REG_UNUSED, 16'hFFFF);
        send_word(10);
        send_word(1000);
        send_word(1000);
        send_word(1000);
        send_word(-1000);   // lockout runs out on a window break
        send_word(-950);
        send_word(-950);
        send_word(-950);    // lockout ends with no new break

        // Widest window, longest hold, unsigned samples; upper data bits ignored
        wait_idle();
        write_reg(pawmd_pkg::REG_WINDOW_SIZE, 16'hFFFF);
        write_reg(pawmd_pkg::REG_HOLD_SAMPLES, 16'hFFFF);
        write_reg(pawmd_pkg::REG_SINGLE_ENDED, 16'hFFFF);
        send_word(65535);
        send_word(0);
        send_word(-32768);
        send_word(40000);

        // Back to signed, window of one (half is zero), zero hold
        wait_idle();
        write_reg(pawmd_pkg::REG_SINGLE_ENDED, 16'h0002);
        write_reg(pawmd_pkg::REG_WINDOW_SIZE, 16'd1);
        write_reg(pawmd_pkg::REG_HOLD_SAMPLES, 16'd0);
        send_word(32767);
        send_word(-32768);

        // Random phases, each with its own settings
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_idle();
            case (p % 5)
                0:       win = 16'($urandom_range(64));
                1:       win = 16'($urandom_range(2000, 200));
                2:       win = 16'hFFFF;
                3:       win = '0;
                default: win = 16'($urandom_range(65535));
            endcase
            case (p % 4)
                0:       hold = '0;
                1:       hold = 16'($urandom_range(4, 1));
                2:       hold = 16'($urandom_range(40, 5));
                default: hold = (p == 7) ? 16'hFFFF : 16'($urandom_range(200));
            endcase
            phase_win = int'(win);
            phase_uns = p[0];
            level     = phase_uns ? 30000 : 0;
            write_reg(pawmd_pkg::REG_WINDOW_SIZE, win);
            write_reg(pawmd_pkg::REG_HOLD_SAMPLES, hold);
            write_reg(pawmd_pkg::REG_SINGLE_ENDED, {15'($urandom_range(32767)), phase_uns});
            if (p == 4)
                write_reg(REG_UNUSED, 16'($urandom_range(65535)));

            // Idling profile for this phase
            tx_idle_pct = 25;
            rx_idle_pct = 25;
            if (p == 3)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (p == 5)
            begin
                tx_idle_pct = 0;
                hold_req    = 1'b1;
            end
            if (p == 8)
                rx_idle_pct = 60;

            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                next_sample(x);
                send_word(x);
            end
        end

        // Let everything drain, then settle
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4 * DUT_LATENCY) @(negedge clk);

        $display("Sent %0d samples over %0d register settings, %0d results checked",
                 words_sent, RANDOM_PHASES + 4, results_seen);
        $display("Motion starts %0d, ends %0d, start and end on the same word %0d",
                 starts_seen, ends_seen, overlaps_seen);
        if (errors == 0 && pending == 0)
            $display("** pir_adaptive_window_motion_detector: PASSED **");
        else
            $display("** pir_adaptive_window_motion_detector: FAILED **");
        $finish;
    end

endmodule
